// ----- rtl/mpes_pkg.sv -----
// ----------------------------------------------------------------------------
// mpes_pkg: shared constants for the multichannel PWM event scheduler
// Holds command codes, register indexes, reset values and level limits.
// ----------------------------------------------------------------------------
package mpes_pkg;

  localparam int unsigned LevelW = 8;
  localparam int unsigned TicksW = 24;
  localparam int unsigned CountW = 32;

  // Top PWM level; a channel at this level never has a falling edge.
  localparam logic [LevelW-1:0] LEVEL_TOP = 8'hFF;

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  localparam logic [1:0] REG_TICKS  = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;

  localparam logic [TicksW-1:0] TICKS_RESET  = 24'd1294;
  localparam logic [CountW-1:0] PERIOD_RESET = 32'd330000;

  // Scaled divisor: ticks per level times 256, the capped quotient range.
  function automatic logic [CountW-1:0] scaled_ticks(input logic [TicksW-1:0] ticks);
    scaled_ticks = {ticks, 8'h00};
  endfunction

endpackage

// ----- rtl/mpes_div.sv -----
// ----------------------------------------------------------------------------
// mpes_div: elapsed-level divider
// Restoring division of a 32-bit tick count by ticks per level, one quotient
// bit per cycle; quotients of 256 and above return 255 in the cycle after start.
// ----------------------------------------------------------------------------
module mpes_div
  import mpes_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CountW-1:0] dividend_i,
  input  logic [TicksW-1:0] divisor_i,
  output logic              done_o,
  output logic [LevelW-1:0] quot_o
);

  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] dsh_q, dsh_d;
  logic [LevelW-1:0] quot_q, quot_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CountW-1:0] limit;
  logic              ge;

  assign limit = scaled_ticks(divisor_i);
  assign ge    = (rem_q >= dsh_q);

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      // A zero divisor also lands here, which gives the top level.
      if (dividend_i >= limit) begin
        quot_d = LEVEL_TOP;
        done_d = 1'b1;
      end else begin
        rem_d  = dividend_i;
        dsh_d  = limit >> 1;
        quot_d = '0;
        cnt_d  = '0;
        run_d  = 1'b1;
      end
    end else if (run_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[LevelW-2:0], ge};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/multichannel_pwm_event_scheduler.sv -----
// ----------------------------------------------------------------------------
// multichannel_pwm_event_scheduler: multichannel 8-bit PWM event scheduler
// Keeps per-channel levels and pins, and at each compare event walks the
// channels to update pins and find the next edge for one compare register.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  command   start_i / busy_o          command_i, channel_i, channel_enable_i,
//                                      level_i, invert_level_i, counter_now_i
//  result    done_o (one-cycle strobe) pin_mask_o, compare_value_o,
//                                      compare_valid_o
//  config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A set item goes from ST_IDLE straight to ST_RESP. A compare event walks one channel
// per cycle, then passes ST_MUL, ST_TGT and ST_FIX; in the next phase the 8-step
// elapsed-level divider runs first in ST_DIV (its steps are skipped when the
// elapsed level is capped). The result strobe comes in ST_RESP, the last busy
// state, and busy_o falls after it. Reset is asynchronous and clears all
// channels; the result side never stalls.
// ----------------------------------------------------------------------------
module multichannel_pwm_event_scheduler
  import mpes_pkg::*;
#(
  parameter int unsigned CHANNELS = 32
)(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              command_i,
  input  logic [4:0]        channel_i,
  input  logic              channel_enable_i,
  input  logic [LevelW-1:0] level_i,
  input  logic              invert_level_i,
  input  logic [CountW-1:0] counter_now_i,
  output logic              done_o,
  output logic [31:0]       pin_mask_o,
  output logic [CountW-1:0] compare_value_o,
  output logic              compare_valid_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_TGT  = 3'd4;
  localparam logic [2:0] ST_FIX  = 3'd5;
  localparam logic [2:0] ST_RESP = 3'd6;

  logic [2:0]          state_q;
  logic [LevelW-1:0]   lvl_q [CHANNELS];
  logic [CHANNELS-1:0] en_q;
  logic [CHANNELS-1:0] pin_q;
  logic [CountW-1:0]   ps_q;
  logic                phase_q;
  logic [TicksW-1:0]   tpl_q;
  logic [CountW-1:0]   period_q;
  logic [CW-1:0]       idx_q;
  logic [LevelW-1:0]   next_q;
  logic [LevelW-1:0]   elapsed_q;
  logic [CountW-1:0]   now_q;
  logic [CountW-1:0]   prod_q;
  logic [CountW-1:0]   target_q;
  logic [CountW-1:0]   cmp_q;
  logic                cmpv_q;

  logic              accept;
  logic [6:0]        chan_ext;
  logic [CW-1:0]     wr_idx;
  logic              div_start;
  logic              div_done;
  logic [LevelW-1:0] div_quot;
  logic [LevelW-1:0] cur_lvl;
  logic              cur_en;
  logic [CountW-1:0] ps_new;
  logic [CountW-1:0] late_diff;

  assign accept    = start_i && !busy_o;
  assign chan_ext  = {2'b00, channel_i};
  assign wr_idx    = chan_ext[CW-1:0];
  assign div_start = accept && (command_i == CMD_EVENT) && phase_q;
  assign cur_lvl   = lvl_q[idx_q];
  assign cur_en    = en_q[idx_q];
  assign ps_new    = ps_q - period_q;
  assign late_diff = now_q - target_q;

  mpes_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ps_q - counter_now_i),
    .divisor_i  (tpl_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpl_q    <= TICKS_RESET;
      period_q <= PERIOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_TICKS) begin
        tpl_q <= cfg_data_i[TicksW-1:0];
      end else if (cfg_index_i == REG_PERIOD) begin
        period_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lvl_q     <= '{default: '0};
      en_q      <= '0;
      pin_q     <= '0;
      ps_q      <= '0;
      phase_q   <= 1'b0;
      idx_q     <= '0;
      next_q    <= LEVEL_TOP;
      elapsed_q <= '0;
      now_q     <= '0;
      prod_q    <= '0;
      target_q  <= '0;
      cmp_q     <= '0;
      cmpv_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            now_q  <= counter_now_i;
            idx_q  <= '0;
            next_q <= LEVEL_TOP;
            if (command_i == CMD_SET) begin
              cmp_q   <= '0;
              cmpv_q  <= 1'b0;
              state_q <= ST_RESP;
              if (chan_ext < 7'(CHANNELS)) begin
                lvl_q[wr_idx] <= invert_level_i ? (LEVEL_TOP - level_i) : level_i;
                en_q[wr_idx]  <= channel_enable_i;
                if (channel_enable_i) begin
                  pin_q[wr_idx] <= 1'b0;
                end
              end
            end else begin
              cmpv_q  <= 1'b1;
              state_q <= phase_q ? ST_DIV : ST_WALK;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            elapsed_q <= div_quot;
            state_q   <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (cur_en) begin
            if (!phase_q) begin
              pin_q[idx_q] <= (cur_lvl != '0);
              if ((cur_lvl != '0) && (cur_lvl < next_q)) begin
                next_q <= cur_lvl;
              end
            end else if (cur_lvl >= elapsed_q) begin
              if (cur_lvl < next_q) begin
                next_q <= cur_lvl;
              end
            end else begin
              pin_q[idx_q] <= 1'b0;
            end
          end
          if (idx_q == CW'(CHANNELS - 1)) begin
            state_q <= ST_MUL;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        ST_MUL: begin
          prod_q  <= CountW'(next_q) * CountW'(tpl_q);
          state_q <= ST_TGT;
        end
        ST_TGT: begin
          // With no edge left in the next phase, the new period start is the target.
          if (phase_q && (next_q == LEVEL_TOP)) begin
            target_q <= ps_new;
          end else begin
            target_q <= ps_q - prod_q;
          end
          if (next_q == LEVEL_TOP) begin
            ps_q    <= ps_new;
            phase_q <= 1'b0;
          end else begin
            phase_q <= 1'b1;
          end
          state_q <= ST_FIX;
        end
        ST_FIX: begin
          // A target already passed by more than 256 levels is replaced.
          if (late_diff > scaled_ticks(tpl_q)) begin
            cmp_q <= now_q - CountW'(tpl_q);
          end else begin
            cmp_q <= target_q;
          end
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  for (genvar g = 0; g < 32; g++) begin : g_mask
    if (g < CHANNELS) begin : g_on
      assign pin_mask_o[g] = pin_q[g];
    end else begin : g_off
      assign pin_mask_o[g] = 1'b0;
    end
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = (state_q == ST_RESP);
  assign compare_value_o = cmp_q;
  assign compare_valid_o = cmpv_q;
  // Registers change only while no item is in flight or being accepted.
  assign cfg_ready_o     = (state_q == ST_IDLE) && !start_i;

endmodule

// ----- dv/tb_multichannel_pwm_event_scheduler.sv -----
// ----------------------------------------------------------------------------
// tb_multichannel_pwm_event_scheduler: testbench for the PWM event scheduler
// Sends set and compare items with random gaps and keeps a behavioral model
// of the channel levels, pins, period start and phase. Every result strobe
// is checked in order against the model's pin mask, compare value and valid flag.
// ----------------------------------------------------------------------------
module tb_multichannel_pwm_event_scheduler
  import mpes_pkg::*;
();

  localparam int unsigned NumChan       = 32;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned RandomItems   = 205;

  // Register indexes that the block does not implement.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic              command;
    logic [4:0]        channel;
    logic              enable;
    logic [LevelW-1:0] level;
    logic              invert_level;
    logic [CountW-1:0] counter_now;
  } pwm_item_t;

  typedef struct packed {
    logic [31:0]       pin_mask;
    logic [CountW-1:0] compare_value;
    logic              compare_valid;
  } pwm_result_t;

  logic              clk_i;
  logic              rst_ni           = 1'b0;
  logic              start_i          = 1'b0;
  logic              busy_o;
  logic              command_i        = CMD_SET;
  logic [4:0]        channel_i        = '0;
  logic              channel_enable_i = 1'b0;
  logic [LevelW-1:0] level_i          = '0;
  logic              invert_level_i   = 1'b0;
  logic [CountW-1:0] counter_now_i    = '0;
  logic              done_o;
  logic [31:0]       pin_mask_o;
  logic [CountW-1:0] compare_value_o;
  logic              compare_valid_o;
  logic              cfg_valid_i      = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i      = REG_TICKS;
  logic [31:0]       cfg_data_i       = '0;

  // Model of the scheduler state.
  logic [LevelW-1:0] duty_q [NumChan];
  logic [NumChan-1:0] enabled_q;
  logic [NumChan-1:0] pins_q;
  logic [CountW-1:0] period_start_q;
  logic              next_phase_q;
  logic [TicksW-1:0] ticks_q;
  logic [CountW-1:0] period_q;
  logic [CountW-1:0] last_compare;

  pwm_result_t pending_q [$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  bit          burst_mode  = 1'b0;

  multichannel_pwm_event_scheduler #(
    .CHANNELS(NumChan)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .channel_i       (channel_i),
    .channel_enable_i(channel_enable_i),
    .level_i         (level_i),
    .invert_level_i  (invert_level_i),
    .counter_now_i   (counter_now_i),
    .done_o          (done_o),
    .pin_mask_o      (pin_mask_o),
    .compare_value_o (compare_value_o),
    .compare_valid_o (compare_valid_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic clear_schedule();
    for (int i = 0; i < NumChan; i++) duty_q[i] = '0;
    enabled_q      = '0;
    pins_q         = '0;
    period_start_q = '0;
    next_phase_q   = 1'b0;
    ticks_q        = TICKS_RESET;
    period_q       = PERIOD_RESET;
    last_compare   = '0;
  endtask

  // An edge that is already behind the counter by more than 256 level steps
  // is replaced by one step past the current count.
  function automatic logic [CountW-1:0] late_guard(logic [CountW-1:0] target,
                                                   logic [CountW-1:0] now);
    logic [CountW-1:0] lag;
    lag = now - target;
    if (lag > {ticks_q, 8'h00}) return now - {8'h00, ticks_q};
    return target;
  endfunction

  function automatic pwm_result_t schedule_item(pwm_item_t it);
    pwm_result_t       res;
    logic [8:0]        next_edge;
    logic [CountW-1:0] ticks32;
    logic [CountW-1:0] elapsed;
    logic [CountW-1:0] target;
    res       = '0;
    next_edge = {1'b0, LEVEL_TOP};
    ticks32   = {8'h00, ticks_q};
    if (it.command == CMD_SET) begin
      duty_q[it.channel]    = it.invert_level ? (LEVEL_TOP - it.level) : it.level;
      enabled_q[it.channel] = it.enable;
      if (it.enable) pins_q[it.channel] = 1'b0;
    end else begin
      res.compare_valid = 1'b1;
      if (!next_phase_q) begin
        for (int i = 0; i < NumChan; i++) begin
          if (enabled_q[i]) begin
            if (duty_q[i] != '0) begin
              if (duty_q[i] < next_edge) next_edge = duty_q[i];
              pins_q[i] = 1'b1;
            end else begin
              pins_q[i] = 1'b0;
            end
          end
        end
        target = period_start_q - next_edge * ticks32;
        res.compare_value = late_guard(target, it.counter_now);
        if (next_edge >= LEVEL_TOP) period_start_q = period_start_q - period_q;
        else next_phase_q = 1'b1;
      end else begin
        if (ticks_q == '0) elapsed = LEVEL_TOP;
        else elapsed = (period_start_q - it.counter_now) / ticks32;
        if (elapsed > LEVEL_TOP) elapsed = LEVEL_TOP;
        for (int i = 0; i < NumChan; i++) begin
          if (enabled_q[i]) begin
            if ({24'd0, duty_q[i]} >= elapsed) begin
              if (duty_q[i] < next_edge) next_edge = duty_q[i];
            end else begin
              pins_q[i] = 1'b0;
            end
          end
        end
        if (next_edge >= LEVEL_TOP) begin
          period_start_q = period_start_q - period_q;
          target         = period_start_q;
          next_phase_q   = 1'b0;
        end else begin
          target = period_start_q - next_edge * ticks32;
        end
        res.compare_value = late_guard(target, it.counter_now);
      end
      last_compare = res.compare_value;
    end
    res.pin_mask = pins_q;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pwm_item_t set_item(logic [4:0] ch, logic en, logic [LevelW-1:0] lvl,
                                         logic inv);
    pwm_item_t it;
    it              = '0;
    it.command      = CMD_SET;
    it.channel      = ch;
    it.enable       = en;
    it.level        = lvl;
    it.invert_level = inv;
    it.counter_now  = $urandom();
    return it;
  endfunction

  function automatic pwm_item_t event_item(logic [CountW-1:0] now);
    pwm_item_t it;
    it             = '0;
    it.command     = CMD_EVENT;
    it.channel     = $urandom_range(0, 31);
    it.level       = $urandom_range(0, 255);
    it.counter_now = now;
    return it;
  endfunction

  // Mostly compare events that follow the schedule closely, as a real counter
  // would, mixed with channel updates, late events and arbitrary counts.
  function automatic pwm_item_t random_item();
    pwm_item_t   it;
    int unsigned roll;
    it              = '0;
    it.channel      = $urandom_range(0, 31);
    it.enable       = ($urandom_range(0, 3) != 0);
    it.invert_level = $urandom_range(0, 1);
    it.counter_now  = $urandom();
    roll = $urandom_range(0, 9);
    if (roll == 0) it.level = '0;
    else if (roll == 1) it.level = LEVEL_TOP;
    else it.level = $urandom_range(0, 255);
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      it.command = CMD_SET;
    end else begin
      it.command = CMD_EVENT;
      if (roll < 88) it.counter_now = last_compare - $urandom_range(0, 40);
      else if (roll < 94)
        it.counter_now = last_compare - {8'h00, ticks_q} * $urandom_range(257, 600);
    end
    return it;
  endfunction

  task automatic send_item(pwm_item_t it);
    int unsigned gap;
    start_i          <= 1'b1;
    command_i        <= it.command;
    channel_i        <= it.channel;
    channel_enable_i <= it.enable;
    level_i          <= it.level;
    invert_level_i   <= it.invert_level;
    counter_now_i    <= it.counter_now;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_q.push_back(schedule_item(it));
    gap = pick_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_TICKS:  ticks_q  = data[TicksW-1:0];
      REG_PERIOD: period_q = data;
      default: ;
    endcase
    repeat (pick_gap() + 1) @(posedge clk_i);
  endtask

  task automatic set_timing(logic [31:0] ticks, logic [31:0] period);
    settle();
    write_reg(REG_TICKS, ticks);
    write_reg(REG_PERIOD, period);
  endtask

  task automatic follow_schedule(int unsigned count);
    repeat (count) send_item(event_item(last_compare - $urandom_range(0, 8)));
  endtask

  task automatic test_directed_items();
    send_item(event_item('0));
    send_item(set_item(5'd0, 1'b1, 8'd0, 1'b0));
    send_item(set_item(5'd31, 1'b1, 8'd255, 1'b0));
    send_item(set_item(5'd5, 1'b1, 8'd0, 1'b1));
    send_item(set_item(5'd7, 1'b1, 8'd255, 1'b1));
    send_item(set_item(5'd10, 1'b1, 8'd1, 1'b0));
    send_item(set_item(5'd20, 1'b1, 8'd128, 1'b0));
    send_item(set_item(5'd3, 1'b1, 8'd254, 1'b0));
    follow_schedule(5);
    // Disabling keeps the pin; writing an enabled channel clears its pin.
    send_item(set_item(5'd20, 1'b0, 8'd77, 1'b0));
    send_item(set_item(5'd10, 1'b1, 8'd1, 1'b0));
    send_item(event_item(last_compare - {8'h00, ticks_q} * 1000));
    send_item(event_item('0));
    send_item(event_item('1));
    send_item(set_item(5'd31, 1'b0, 8'd0, 1'b0));
    send_item(set_item(5'd16, 1'b1, 8'h55, 1'b1));
    follow_schedule(2);
  endtask

  task automatic test_register_extremes();
    // Upper data bits of the tick register are dropped.
    set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    follow_schedule(3);
    set_timing(32'd1, 32'd1);
    follow_schedule(3);
    // With zero ticks every elapsed level is taken as the top level.
    set_timing(32'd0, 32'd0);
    follow_schedule(3);
  endtask

  task automatic test_unused_registers();
    set_timing(32'd700, 32'd200000);
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, $urandom());
    follow_schedule(2);
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      burst_mode = ((n / 64) % 3 == 2);
      send_item(random_item());
    end
    burst_mode = 1'b0;
  endtask

  task automatic test_random_schedule();
    set_timing({8'h00, TICKS_RESET}, PERIOD_RESET);
    run_random(RandomItems);
    set_timing(32'd1, 32'd255);
    run_random(RandomItems);
    set_timing(32'h00FF_FFFF, 32'hFFFF_FFFF);
    run_random(RandomItems);
    set_timing(32'd0, $urandom());
    run_random(RandomItems);
    set_timing($urandom_range(1, 4000), $urandom());
    run_random(RandomItems);
  endtask

  task automatic flag_mismatch(string why, pwm_result_t want, pwm_result_t got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%s: expected pins %h cmp %h valid %b, got pins %h cmp %h valid %b",
               why, want.pin_mask, want.compare_value, want.compare_valid,
               got.pin_mask, got.compare_value, got.compare_valid);
  endtask

  always @(posedge clk_i) begin
    pwm_result_t got;
    pwm_result_t want;
    if (rst_ni && done_o) begin
      got = {pin_mask_o, compare_value_o, compare_valid_o};
      if (pending_q.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) flag_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("tb_multichannel_pwm_event_scheduler: errors");
    $finish;
  end

  initial begin
    clear_schedule();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_items();
    test_register_extremes();
    test_unused_registers();
    test_random_schedule();
    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("tb_multichannel_pwm_event_scheduler: clean");
    end else begin
      $display("tb_multichannel_pwm_event_scheduler: errors");
    end
    $finish;
  end

endmodule
